[rtl/core/clfs_pkg.sv]
// Shared types and constants for the clocked LED frame serializer.
// Used by the front end, the command queue, the back end and the top level.
package clfs_pkg;

    // Field and state widths.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned NUM_CHANS   = 5;
    localparam int unsigned CHAN_CNT_W  = 3;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned BIT_CNT_W   = 4;
    localparam int unsigned PIX_W       = 10;
    localparam int unsigned PIX_MAX_DEF = 512;

    // The mode 0 trailer is capped at this many chunks of eight bits.
    localparam int unsigned MAX_CHUNKS     = 33;
    localparam int unsigned TRAIL_MAX_BITS = MAX_CHUNKS * BYTE_W;
    localparam int unsigned TRAIL_W        = $clog2(TRAIL_MAX_BITS + 1);

    localparam int unsigned BYTES_W = NUM_CHANS * BYTE_W;
    localparam int unsigned NBYTE_W = $clog2(NUM_CHANS + 1);

    // Command queue between the front and back ends.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIRE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_CHANS = 1'd1;

    localparam logic [MODE_W-1:0]     WIRE_MODE_RST = 3'd0;
    localparam logic [CHAN_CNT_W-1:0] DEF_CHANS_RST = 3'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_END   = 2'd2
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_BRIGHT = 3'd0,
        MODE_FLAG   = 3'd1,
        MODE_SEVEN  = 3'd2,
        MODE_555    = 3'd3,
        MODE_RAW    = 3'd4
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0]     wire_mode;
        logic [CHAN_CNT_W-1:0] def_chans;
    } t_cfg;

    // One unit of work for the back end: either a list of whole bytes sent
    // first byte first, or a run of one bits for the mode 0 trailer.
    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [NBYTE_W-1:0] nbytes;
        logic               ones;
        logic [TRAIL_W-1:0] nones;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_BYTES = 2'd1,
        BK_ONES  = 2'd2
    } t_back_state;

endpackage

[rtl/core/clfs_front.sv]
// Front end of the LED frame serializer: accepts items, keeps the pixel
// count and turns each item into a command for the back end. Uses clfs_pkg.
module clfs_front #(
    parameter int unsigned MAX_PIXELS = clfs_pkg::PIX_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  clfs_pkg::t_cfg                      i_cfg,
    input  logic                                i_accept,
    input  logic [clfs_pkg::KIND_W-1:0]         i_kind,
    input  logic [clfs_pkg::BYTE_W-1:0]         i_chan0,
    input  logic [clfs_pkg::BYTE_W-1:0]         i_chan1,
    input  logic [clfs_pkg::BYTE_W-1:0]         i_chan2,
    input  logic [clfs_pkg::BYTE_W-1:0]         i_chan3,
    input  logic [clfs_pkg::BYTE_W-1:0]         i_chan4,
    input  logic [clfs_pkg::CHAN_CNT_W-1:0]     i_chan_count,
    output logic                                o_push,
    output clfs_pkg::t_cmd                      o_cmd
);

    logic [clfs_pkg::PIX_W-1:0]      r_pix_count;
    logic [clfs_pkg::PIX_W-1:0]      n_pix_count;
    clfs_pkg::t_mode                 mode;
    logic                            has_work;
    logic [clfs_pkg::CHAN_CNT_W-1:0] raw_n;
    logic [clfs_pkg::PIX_W-1:0]      trail_bits;
    logic [15:0]                     word555;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_count <= '0;
        end else begin
            r_pix_count <= n_pix_count;
        end
    end

    always_comb begin
        // Unknown wire modes behave as raw bytes.
        if (i_cfg.wire_mode > clfs_pkg::MODE_RAW) begin
            mode = clfs_pkg::MODE_RAW;
        end else begin
            mode = clfs_pkg::t_mode'(i_cfg.wire_mode);
        end

        raw_n = (i_chan_count == '0) ? i_cfg.def_chans : i_chan_count;
        if (raw_n > clfs_pkg::CHAN_CNT_W'(clfs_pkg::NUM_CHANS)) begin
            raw_n = clfs_pkg::CHAN_CNT_W'(clfs_pkg::NUM_CHANS);
        end

        trail_bits = {1'b0, r_pix_count[clfs_pkg::PIX_W-1:1]} + clfs_pkg::PIX_W'(1);
        if (trail_bits > clfs_pkg::PIX_W'(clfs_pkg::TRAIL_MAX_BITS)) begin
            trail_bits = clfs_pkg::PIX_W'(clfs_pkg::TRAIL_MAX_BITS);
        end

        word555 = {1'b1, i_chan0[7:3], i_chan1[7:3], i_chan2[7:3]};

        n_pix_count = r_pix_count;
        o_cmd       = '0;
        unique case (i_kind)
            clfs_pkg::KIND_START: begin
                if (i_accept) begin
                    n_pix_count = '0;
                end
                unique case (mode)
                    clfs_pkg::MODE_SEVEN: o_cmd.nbytes = clfs_pkg::NBYTE_W'(3);
                    clfs_pkg::MODE_RAW:   o_cmd.nbytes = '0;
                    default:              o_cmd.nbytes = clfs_pkg::NBYTE_W'(4);
                endcase
            end
            clfs_pkg::KIND_PIXEL: begin
                if (i_accept && (r_pix_count < clfs_pkg::PIX_W'(MAX_PIXELS))) begin
                    n_pix_count = r_pix_count + clfs_pkg::PIX_W'(1);
                end
                unique case (mode)
                    clfs_pkg::MODE_BRIGHT: begin
                        o_cmd.bytes  = {8'hFF, i_chan0, i_chan1, i_chan2, 8'h00};
                        o_cmd.nbytes = clfs_pkg::NBYTE_W'(4);
                    end
                    clfs_pkg::MODE_FLAG: begin
                        o_cmd.bytes  = {2'b11, ~i_chan2[7:6], ~i_chan1[7:6],
                                        ~i_chan0[7:6], i_chan2, i_chan1, i_chan0, 8'h00};
                        o_cmd.nbytes = clfs_pkg::NBYTE_W'(4);
                    end
                    clfs_pkg::MODE_SEVEN: begin
                        o_cmd.bytes  = {1'b1, i_chan1[7:1], 1'b1, i_chan0[7:1],
                                        1'b1, i_chan2[7:1], 16'h0000};
                        o_cmd.nbytes = clfs_pkg::NBYTE_W'(3);
                    end
                    clfs_pkg::MODE_555: begin
                        o_cmd.bytes  = {word555, 24'h000000};
                        o_cmd.nbytes = clfs_pkg::NBYTE_W'(2);
                    end
                    default: begin
                        o_cmd.bytes  = {i_chan0, i_chan1, i_chan2, i_chan3, i_chan4};
                        o_cmd.nbytes = clfs_pkg::NBYTE_W'(raw_n);
                    end
                endcase
            end
            clfs_pkg::KIND_END: begin
                unique case (mode)
                    clfs_pkg::MODE_BRIGHT: begin
                        o_cmd.ones  = 1'b1;
                        o_cmd.nones = clfs_pkg::TRAIL_W'(trail_bits);
                    end
                    clfs_pkg::MODE_SEVEN: o_cmd.nbytes = clfs_pkg::NBYTE_W'(3);
                    clfs_pkg::MODE_RAW:   o_cmd.nbytes = clfs_pkg::NBYTE_W'(2);
                    default:              o_cmd.nbytes = clfs_pkg::NBYTE_W'(4);
                endcase
            end
            default: begin
                // Kind 3 carries no work and leaves the count alone.
            end
        endcase

        has_work = o_cmd.ones || (o_cmd.nbytes != '0);
        o_push   = i_accept && has_work;
    end

endmodule

[rtl/core/clfs_cmd_queue.sv]
// Short command queue between the front and back ends of the serializer.
// Holds clfs_pkg::t_cmd entries; depth comes from clfs_pkg.
module clfs_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clfs_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output clfs_pkg::t_cmd  o_cmd
);

    localparam int unsigned PTR_W = (clfs_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(clfs_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(clfs_pkg::QUEUE_DEPTH + 1);

    clfs_pkg::t_cmd   r_mem [clfs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(clfs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(clfs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(clfs_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/core/clfs_back.sv]
// Back end of the serializer: takes commands from the queue and sends them
// as chunks of up to eight bits through an output register. Uses clfs_pkg.
module clfs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_empty,
    input  clfs_pkg::t_cmd                     i_q_cmd,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [clfs_pkg::BYTE_W-1:0]        o_out_bits,
    output logic [clfs_pkg::BIT_CNT_W-1:0]     o_bit_count,
    output logic                               o_last
);

    clfs_pkg::t_back_state           r_state;
    clfs_pkg::t_back_state           n_state;
    logic [clfs_pkg::BYTES_W-1:0]    r_bytes;
    logic [clfs_pkg::BYTES_W-1:0]    n_bytes;
    logic [clfs_pkg::NBYTE_W-1:0]    r_left;
    logic [clfs_pkg::NBYTE_W-1:0]    n_left;
    logic [clfs_pkg::TRAIL_W-1:0]    r_ones;
    logic [clfs_pkg::TRAIL_W-1:0]    n_ones;

    logic                            r_out_valid;
    logic [clfs_pkg::BYTE_W-1:0]     r_out_bits;
    logic [clfs_pkg::BIT_CNT_W-1:0]  r_bit_count;
    logic                            r_last;

    logic                            slot_free;
    logic                            emit;
    logic [clfs_pkg::BYTE_W-1:0]     emit_bits;
    logic [clfs_pkg::BIT_CNT_W-1:0]  emit_count;
    logic                            emit_last;
    logic [clfs_pkg::BIT_CNT_W-1:0]  ones_n;

    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clfs_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_left  <= n_left;
        r_ones  <= n_ones;
        if (emit) begin
            r_out_bits  <= emit_bits;
            r_bit_count <= emit_count;
            r_last      <= emit_last;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_bytes    = r_bytes;
        n_left     = r_left;
        n_ones     = r_ones;
        o_q_pop    = 1'b0;
        emit       = 1'b0;
        emit_bits  = r_bytes[clfs_pkg::BYTES_W-1 -: clfs_pkg::BYTE_W];
        emit_count = clfs_pkg::BIT_CNT_W'(clfs_pkg::BYTE_W);
        emit_last  = 1'b0;
        ones_n     = (r_ones >= clfs_pkg::TRAIL_W'(clfs_pkg::BYTE_W)) ?
                     clfs_pkg::BIT_CNT_W'(clfs_pkg::BYTE_W) :
                     clfs_pkg::BIT_CNT_W'(r_ones);

        unique case (r_state)
            clfs_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_bytes = i_q_cmd.bytes;
                    n_left  = i_q_cmd.nbytes;
                    n_ones  = i_q_cmd.nones;
                    n_state = i_q_cmd.ones ? clfs_pkg::BK_ONES : clfs_pkg::BK_BYTES;
                end
            end
            clfs_pkg::BK_BYTES: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    emit_last = (r_left == clfs_pkg::NBYTE_W'(1));
                    n_bytes   = {r_bytes[clfs_pkg::BYTES_W-clfs_pkg::BYTE_W-1:0],
                                 {clfs_pkg::BYTE_W{1'b0}}};
                    n_left    = r_left - clfs_pkg::NBYTE_W'(1);
                    if (emit_last) begin
                        n_state = clfs_pkg::BK_IDLE;
                    end
                end
            end
            clfs_pkg::BK_ONES: begin
                if (slot_free) begin
                    // A short final chunk keeps its one bits in the low positions.
                    emit       = 1'b1;
                    emit_bits  = 8'hFF >> (clfs_pkg::BIT_CNT_W'(clfs_pkg::BYTE_W) - ones_n);
                    emit_count = ones_n;
                    emit_last  = (r_ones <= clfs_pkg::TRAIL_W'(clfs_pkg::BYTE_W));
                    n_ones     = r_ones - clfs_pkg::TRAIL_W'(ones_n);
                    if (emit_last) begin
                        n_state = clfs_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = clfs_pkg::BK_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_bits  = r_out_bits;
    assign o_bit_count = r_bit_count;
    assign o_last      = r_last;

endmodule

[rtl/core/clocked_led_frame_serializer_core.sv]
// Clocked LED frame serializer. A start item emits the wire format's header
// (none in raw mode), each pixel item emits that pixel's bytes and an end
// item emits the trailer, all as chunks of up to eight bits sent MSB first
// from bit bit_count-1. The front end classifies an item in the cycle it is
// accepted and places a command in a two-entry queue, so it keeps taking
// items while the output is stalled until the queue is full. The back end
// fetches a command from the queue and then sends one chunk per cycle through
// its output register while the output is not stalled. Items that cause no
// chunk pass through the front end only. No clearing pass is needed after
// reset.
module clocked_led_frame_serializer_core #(
    parameter int unsigned MAX_PIXELS = clfs_pkg::PIX_MAX_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [clfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [clfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input items.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [clfs_pkg::KIND_W-1:0]        i_kind,
    input  logic [clfs_pkg::BYTE_W-1:0]        i_chan0,
    input  logic [clfs_pkg::BYTE_W-1:0]        i_chan1,
    input  logic [clfs_pkg::BYTE_W-1:0]        i_chan2,
    input  logic [clfs_pkg::BYTE_W-1:0]        i_chan3,
    input  logic [clfs_pkg::BYTE_W-1:0]        i_chan4,
    input  logic [clfs_pkg::CHAN_CNT_W-1:0]    i_chan_count,
    // Result chunks.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [clfs_pkg::BYTE_W-1:0]        o_out_bits,
    output logic [clfs_pkg::BIT_CNT_W-1:0]     o_bit_count,
    output logic                               o_last
);

    clfs_pkg::t_cfg r_cfg;
    clfs_pkg::t_cmd front_cmd;
    clfs_pkg::t_cmd q_cmd;
    logic           in_accept;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wire_mode <= clfs_pkg::WIRE_MODE_RST;
            r_cfg.def_chans <= clfs_pkg::DEF_CHANS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                clfs_pkg::CFG_WIRE_MODE: r_cfg.wire_mode <= i_cfg_data;
                clfs_pkg::CFG_DEF_CHANS: r_cfg.def_chans <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A full queue holds off the next transaction.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !o_in_stall;

    clfs_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_accept     (in_accept),
        .i_kind       (i_kind),
        .i_chan0      (i_chan0),
        .i_chan1      (i_chan1),
        .i_chan2      (i_chan2),
        .i_chan3      (i_chan3),
        .i_chan4      (i_chan4),
        .i_chan_count (i_chan_count),
        .o_push       (q_push),
        .o_cmd        (front_cmd)
    );

    clfs_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    clfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_bits  (o_out_bits),
        .o_bit_count (o_bit_count),
        .o_last      (o_last)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bit_count != '0) &&
                        (o_bit_count <= clfs_pkg::BIT_CNT_W'(clfs_pkg::BYTE_W)))
        else $error("chunk bit count out of range");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_bit_count != clfs_pkg::BIT_CNT_W'(clfs_pkg::BYTE_W)))
        |-> o_last)
        else $error("short chunk that does not close its transaction");

endmodule
